>>> rtl/core/ddwb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and fixed-point constants of the differential drive wheel balancer.
// Used by ddwb_step and by the top level; depends on nothing else.
package ddwb_pkg;

	localparam int COUNT_BITS = 16;
	localparam int ERROR_BITS = 24;

	localparam int GAIN_W    = 16;
	localparam int BASE_W    = 9;
	localparam int HOLES_W   = 8;
	localparam int CFG_W     = 16;
	localparam int REM_W     = 10;
	localparam int OUT_ERR_W = 24;

	localparam int PROD_W = COUNT_BITS + GAIN_W + 2;
	localparam int SUM_W  = ((PROD_W > ERROR_BITS) ? PROD_W : ERROR_BITS) + 1;
	localparam int LVL_W  = ((ERROR_BITS > 18) ? ERROR_BITS : 18) + 1;
	localparam int SAT_W  = (ERROR_BITS > OUT_ERR_W) ? ERROR_BITS : OUT_ERR_W;

	localparam logic signed [SUM_W-1:0] ERR_MAX = SUM_W'((64'sd1 <<< (ERROR_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] ERR_MIN = -ERR_MAX - SUM_W'(1);
	localparam logic signed [SAT_W-1:0] OUT_MAX = SAT_W'((64'sd1 <<< (OUT_ERR_W - 1)) - 64'sd1);
	localparam logic signed [SAT_W-1:0] OUT_MIN = -OUT_MAX - SAT_W'(1);

	localparam logic signed [LVL_W-1:0] LVL_LOW  = LVL_W'(100 * 256);
	localparam logic signed [LVL_W-1:0] LVL_HIGH = LVL_W'(255 * 256);

	// Turn target: (4 * holes * degrees + 360) / 720, done as a reciprocal multiply.
	localparam int DEG_W   = 9;
	localparam int HM_W    = HOLES_W + DEG_W;
	localparam int NUM_W   = HM_W + 2;
	localparam int RECIP_W = 20;
	localparam int RECIP_SHIFT = 29;
	localparam logic [RECIP_W-1:0] RECIP_720 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd719) / 64'd720);
	localparam logic [DEG_W-1:0] DEG_LIMIT = DEG_W'(360);

	localparam logic [1:0] DRV_STOP     = 2'b00;
	localparam logic [1:0] DRV_FORWARD  = 2'b01;
	localparam logic [1:0] DRV_STOP_ALT = 2'b10;
	localparam logic [1:0] DRV_BACKWARD = 2'b11;

	typedef enum logic [1:0] {
		OP_LEFT_PULSE  = 2'd0,
		OP_RIGHT_PULSE = 2'd1,
		OP_DRIVE       = 2'd2,
		OP_TURN        = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_BASE_SPEED  = 2'd0,
		REG_DRIVE_DIR   = 2'd1,
		REG_HOLES       = 2'd2,
		REG_ERROR_GAIN  = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		WHEEL_STOP     = 2'd0,
		WHEEL_FORWARD  = 2'd1,
		WHEEL_BACKWARD = 2'd2
	} wheel_dir_t;

	typedef struct packed {
		wheel_dir_t dir;
		logic [7:0] pwm;
	} wheel_cmd_t;

	localparam wheel_cmd_t CMD_STOP = '{dir: WHEEL_STOP, pwm: 8'd0};

	typedef struct packed {
		logic [COUNT_BITS-1:0]        left_pulses;
		logic [COUNT_BITS-1:0]        right_pulses;
		logic [COUNT_BITS-1:0]        left_seen;
		logic [COUNT_BITS-1:0]        right_seen;
		logic [31:0]                  last_ms;
		logic signed [ERROR_BITS-1:0] err;
		logic [REM_W-1:0]             left_rem;
		logic [REM_W-1:0]             right_rem;
		wheel_cmd_t                   left_cmd;
		wheel_cmd_t                   right_cmd;
		logic [1:0]                   direction;
	} state_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [31:0]        time_ms;
		logic signed [15:0] turn_degrees;
		logic signed [15:0] turn_speed;
		logic [HM_W-1:0]    holes_deg;
	} item_t;

	typedef struct packed {
		wheel_dir_t                  left_dir;
		logic [7:0]                  left_pwm;
		wheel_dir_t                  right_dir;
		logic [7:0]                  right_pwm;
		logic                        turn_active;
		logic                        item_ignored;
		logic signed [OUT_ERR_W-1:0] balance_error;
	} result_t;

endpackage

>>> rtl/core/ddwb_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one word: pulse counting, balance integration,
// drive levels and counted turns. Depends on ddwb_pkg.
module ddwb_step import ddwb_pkg::*; (
	input  state_t              st,
	input  item_t               it,
	input  logic [BASE_W-1:0]   base_speed,
	input  logic [GAIN_W-1:0]   error_gain,
	output state_t              st_next,
	output result_t             res
);

	function automatic logic [7:0] drive_level(input logic signed [LVL_W-1:0] q8);
		logic [7:0] lvl;
		if (q8 < LVL_LOW) begin
			lvl = 8'd100;
		end else if (q8 > LVL_HIGH) begin
			lvl = 8'd255;
		end else begin
			lvl = q8[15:8];
		end
		return lvl;
	endfunction

	logic [COUNT_BITS-1:0]        delta_l, delta_r;
	logic signed [COUNT_BITS:0]   diff;
	logic signed [GAIN_W:0]       gain_s;
	logic signed [PROD_W-1:0]     prod;
	logic signed [SUM_W-1:0]      sum;
	logic signed [ERROR_BITS-1:0] err_int, err_use;
	logic                         active, integrate;
	logic signed [LVL_W-1:0]      base_q8, lsum, rsum;
	logic [7:0]                   lvl_l, lvl_r;
	logic signed [16:0]           spd_x;
	logic [16:0]                  spd_mag;
	logic [7:0]                   turn_pwm;
	logic                         spd_neg, left_turn, left_fwd;
	logic [NUM_W-1:0]             num;
	logic [NUM_W+RECIP_W-1:0]     qprod;
	logic [REM_W-1:0]             needed;
	logic signed [SAT_W-1:0]      err_ext;
	logic                         ignored;

	assign delta_l = st.left_pulses - st.left_seen;
	assign delta_r = st.right_pulses - st.right_seen;
	assign diff    = $signed({1'b0, delta_l}) - $signed({1'b0, delta_r});
	assign gain_s  = $signed({1'b0, error_gain});
	assign prod    = diff * gain_s;
	assign sum     = SUM_W'(st.err) + SUM_W'(prod);

	assign err_int = (sum > ERR_MAX) ? ERR_MAX[ERROR_BITS-1:0] :
	                 (sum < ERR_MIN) ? ERR_MIN[ERROR_BITS-1:0] : sum[ERROR_BITS-1:0];

	assign active    = (st.left_rem != '0) || (st.right_rem != '0);
	assign integrate = (it.time_ms != st.last_ms);
	assign err_use   = integrate ? err_int : st.err;

	assign base_q8 = LVL_W'($signed({1'b0, base_speed, 8'd0}));
	assign lsum    = base_q8 - LVL_W'(err_use);
	assign rsum    = base_q8 + LVL_W'(err_use);
	assign lvl_l   = drive_level(lsum);
	assign lvl_r   = drive_level(rsum);

	assign spd_x     = 17'(it.turn_speed);
	assign spd_neg   = it.turn_speed < 0;
	assign spd_mag   = spd_neg ? 17'(-spd_x) : 17'(spd_x);
	assign turn_pwm  = (spd_mag > 17'd255) ? 8'd255 : spd_mag[7:0];
	assign left_turn = it.turn_degrees < 0;
	assign left_fwd  = (spd_neg == left_turn);

	assign num    = {it.holes_deg, 2'b00} + NUM_W'(360);
	assign qprod  = num * RECIP_720;
	assign needed = qprod[RECIP_SHIFT +: REM_W];

	always_comb begin
		st_next = st;
		ignored = 1'b0;
		case (it.opcode)
			OP_LEFT_PULSE: begin
				st_next.left_pulses = st.left_pulses + 1'b1;
				if (st.left_rem != '0) begin
					st_next.left_rem = st.left_rem - 1'b1;
					if (st.left_rem == REM_W'(1)) begin
						st_next.left_cmd = CMD_STOP;
					end
				end
			end
			OP_RIGHT_PULSE: begin
				st_next.right_pulses = st.right_pulses + 1'b1;
				if (st.right_rem != '0) begin
					st_next.right_rem = st.right_rem - 1'b1;
					if (st.right_rem == REM_W'(1)) begin
						st_next.right_cmd = CMD_STOP;
					end
				end
			end
			OP_DRIVE: begin
				if (active) begin
					ignored = 1'b1;
				end else begin
					if (integrate) begin
						st_next.last_ms    = it.time_ms;
						st_next.left_seen  = st.left_pulses;
						st_next.right_seen = st.right_pulses;
						st_next.err        = err_int;
					end
					case (st.direction)
						DRV_FORWARD: begin
							st_next.left_cmd  = '{dir: WHEEL_FORWARD, pwm: lvl_l};
							st_next.right_cmd = '{dir: WHEEL_FORWARD, pwm: lvl_r};
						end
						DRV_BACKWARD: begin
							st_next.left_cmd  = '{dir: WHEEL_BACKWARD, pwm: lvl_l};
							st_next.right_cmd = '{dir: WHEEL_BACKWARD, pwm: lvl_r};
						end
						default: begin
							st_next.left_cmd  = CMD_STOP;
							st_next.right_cmd = CMD_STOP;
						end
					endcase
				end
			end
			OP_TURN: begin
				if (it.turn_speed == 16'sd0) begin
					st_next.direction = DRV_STOP;
					st_next.left_cmd  = CMD_STOP;
					st_next.right_cmd = CMD_STOP;
					st_next.left_rem  = '0;
					st_next.right_rem = '0;
				end else if (it.turn_degrees != 16'sd0) begin
					st_next.direction = DRV_STOP;
					st_next.left_rem  = needed;
					st_next.right_rem = needed;
					if (needed == '0) begin
						st_next.left_cmd  = CMD_STOP;
						st_next.right_cmd = CMD_STOP;
					end else begin
						st_next.left_cmd  = '{dir: left_fwd ? WHEEL_FORWARD : WHEEL_BACKWARD,
						                      pwm: turn_pwm};
						st_next.right_cmd = '{dir: left_fwd ? WHEEL_BACKWARD : WHEEL_FORWARD,
						                      pwm: turn_pwm};
					end
				end
			end
			default: begin
				st_next = st;
			end
		endcase
	end

	assign err_ext = SAT_W'(st_next.err);

	always_comb begin
		res.left_dir     = st_next.left_cmd.dir;
		res.left_pwm     = st_next.left_cmd.pwm;
		res.right_dir    = st_next.right_cmd.dir;
		res.right_pwm    = st_next.right_cmd.pwm;
		res.turn_active  = (st_next.left_rem != '0) || (st_next.right_rem != '0);
		res.item_ignored = ignored;
		if (err_ext > OUT_MAX) begin
			res.balance_error = OUT_MAX[OUT_ERR_W-1:0];
		end else if (err_ext < OUT_MIN) begin
			res.balance_error = OUT_MIN[OUT_ERR_W-1:0];
		end else begin
			res.balance_error = err_ext[OUT_ERR_W-1:0];
		end
	end

endmodule

>>> rtl/core/differential_drive_wheel_balancer.sv
`timescale 1ns / 1ps
// Top level of the differential drive wheel balancer: stream ports, configuration
// registers, controller state and the output register. Depends on ddwb_pkg and ddwb_step.
//
// One word is accepted every clock cycle unless both registers are full and the master
// side stalls. Each word yields exactly one result word, which passes through the input
// register, where the whole update against the controller state is worked out, and then
// the output register. A word's state update is written with its result, so the next word
// sees it at once. The output register holds a result while the master side stalls, and
// the input register keeps taking one more word meanwhile. The user must write
// configuration through the plain write port only while no words are in flight; the block
// does not enforce this. Writing 0 or -2 to drive_direction stops both wheels at once.
module differential_drive_wheel_balancer import ddwb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,   // time_ms[31:0], turn_degrees[47:32], turn_speed[63:48]
	input  logic [1:0]        s_tuser,   // opcode[1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [47:0]       m_tdata,   // left_dir[1:0], left_pwm[9:2], right_dir[11:10],
	                                     // right_pwm[19:12], turn_active[20], item_ignored[21],
	                                     // balance_error[45:22], zero[47:46]
	input  logic              cfg_wen,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	logic [BASE_W-1:0]  base_q;
	logic [HOLES_W-1:0] holes_q;
	logic [GAIN_W-1:0]  gain_q;
	state_t             state_q, st_next;
	item_t              item_s1, item_in;
	logic               valid_s1;
	logic               out_valid_q;
	logic [47:0]        out_data_q;
	result_t            res;
	logic               accept, advance;
	logic signed [16:0] deg_x;
	logic [16:0]        deg_mag;
	logic [DEG_W-1:0]   deg_clamp;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign deg_x     = 17'($signed(s_tdata[47:32]));
	assign deg_mag   = (deg_x < 0) ? 17'(-deg_x) : 17'(deg_x);
	assign deg_clamp = (deg_mag > 17'(DEG_LIMIT)) ? DEG_LIMIT : deg_mag[DEG_W-1:0];

	always_comb begin
		item_in.opcode       = opcode_t'(s_tuser);
		item_in.time_ms      = s_tdata[31:0];
		item_in.turn_degrees = $signed(s_tdata[47:32]);
		item_in.turn_speed   = $signed(s_tdata[63:48]);
		item_in.holes_deg    = HM_W'(holes_q * deg_clamp);
	end

	ddwb_step u_step (
		.st         (state_q),
		.it         (item_s1),
		.base_speed (base_q),
		.error_gain (gain_q),
		.st_next    (st_next),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			out_data_q <= {2'b00, res.balance_error, res.item_ignored, res.turn_active,
			               res.right_pwm, res.right_dir, res.left_pwm, res.left_dir};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q            <= BASE_W'(150);
			holes_q           <= HOLES_W'(20);
			gain_q            <= GAIN_W'(1306);
			state_q.left_pulses  <= '0;
			state_q.right_pulses <= '0;
			state_q.left_seen    <= '0;
			state_q.right_seen   <= '0;
			state_q.last_ms      <= '0;
			state_q.err          <= '0;
			state_q.left_rem     <= '0;
			state_q.right_rem    <= '0;
			state_q.left_cmd     <= CMD_STOP;
			state_q.right_cmd    <= CMD_STOP;
			state_q.direction    <= DRV_STOP;
		end else if (cfg_wen) begin
			case (reg_index_t'(cfg_index))
				REG_BASE_SPEED: begin
					base_q <= cfg_data[BASE_W-1:0];
				end
				REG_DRIVE_DIR: begin
					state_q.direction <= cfg_data[1:0];
					if (cfg_data[1:0] == DRV_STOP || cfg_data[1:0] == DRV_STOP_ALT) begin
						state_q.left_cmd  <= CMD_STOP;
						state_q.right_cmd <= CMD_STOP;
					end
				end
				REG_HOLES: begin
					holes_q <= cfg_data[HOLES_W-1:0];
				end
				REG_ERROR_GAIN: begin
					gain_q <= cfg_data[GAIN_W-1:0];
				end
				default: begin
					base_q <= base_q;
				end
			endcase
		end else if (advance) begin
			state_q <= st_next;
		end
	end

endmodule
